// ===== design/cfe_pkg.sv =====
package cfe_pkg;

    localparam logic [7:0]  FRAME_TAG   = 8'hFD;
    localparam int          MIN_FRAME   = 21;
    localparam int          HDR_LEN     = 17;
    localparam int          BODY_OFS    = 4;
    localparam int          DATA_OFS    = 21;
    localparam int          ID_LO_OFS   = 14;
    localparam int          ID_HI_OFS   = 15;
    localparam int          LEN_HI_OFS  = 5;
    localparam int          STATUS_IDX  = 17;
    localparam int          CRC_BYTES   = 4;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

    localparam logic [2:0] OC_BYTE   = 3'd0;
    localparam logic [2:0] OC_BAD_ID = 3'd1;
    localparam logic [2:0] OC_SHORT  = 3'd2;
    localparam logic [2:0] OC_CRC    = 3'd3;
    localparam logic [2:0] OC_LEN    = 3'd4;

    localparam logic [7:0] ST_OK    = 8'd0;
    localparam logic [7:0] ST_UNSUP = 8'd4;
    localparam logic [7:0] ST_EMPTY = 8'd9;

    localparam logic [15:0] MSG_ID_MAX = 16'd6;

    typedef enum logic [3:0] {
        B_IDLE,
        B_HDR,
        B_LCHK,
        B_CRC,
        B_CCHK,
        B_IDR,
        B_DISP,
        B_WR,
        B_SCAN,
        B_RSTART,
        B_RCRC,
        B_EMIT,
        B_DROP,
        B_DONE
    } t_bstate;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
        end
        return v;
    endfunction

endpackage

// ===== design/cfe_rx_if.sv =====
interface cfe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [7:0] report_tag;
    logic       end_of_report;

    modport source(output valid, rx_byte, report_tag, end_of_report, input ready);
    modport sink(input valid, rx_byte, report_tag, end_of_report, output ready);
endinterface

// ===== design/cfe_tx_if.sv =====
interface cfe_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [2:0] outcome;

    modport source(output valid, tx_byte, tx_last, outcome, input ready);
    modport sink(input valid, tx_byte, tx_last, outcome, output ready);
endinterface

// ===== design/cfe_ram.sv =====
module cfe_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/cfe_jobq.sv =====
module cfe_jobq #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule

// ===== design/cfe_front.sv =====
module cfe_front import cfe_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cfe_rx_if.sink                         i_rx,
    input  logic                           i_q_full,
    output logic                           o_push,
    output logic [$clog2(MAX_FRAME+1)-1:0] o_job_n,
    output logic                           o_job_tag,
    output logic                           o_job_buf,
    output logic                           o_we,
    output logic [$clog2(MAX_FRAME):0]     o_waddr,
    output logic [7:0]                     o_wdata
);
    localparam int CW  = $clog2(MAX_FRAME + 1);
    localparam int FAW = $clog2(MAX_FRAME);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_tag, n_tag;
    logic          r_buf, n_buf;
    logic          acc, room, tag_now;
    logic [CW-1:0] cnt_next;

    assign i_rx.ready = !i_q_full;
    assign acc        = i_rx.valid && !i_q_full;
    assign room       = (r_cnt < CW'(MAX_FRAME));
    assign tag_now    = (r_cnt == '0) ? (i_rx.report_tag == FRAME_TAG) : r_tag;
    assign cnt_next   = room ? r_cnt + CW'(1) : r_cnt;

    assign o_we      = acc && room;
    assign o_waddr   = {r_buf, r_cnt[FAW-1:0]};
    assign o_wdata   = i_rx.rx_byte;
    assign o_push    = acc && i_rx.end_of_report;
    assign o_job_n   = cnt_next;
    assign o_job_tag = tag_now;
    assign o_job_buf = r_buf;

    always_comb begin
        n_cnt = r_cnt;
        n_tag = r_tag;
        n_buf = r_buf;
        if (acc) begin
            if (i_rx.end_of_report) begin
                n_cnt = '0;
                n_tag = 1'b0;
                n_buf = ~r_buf;
            end else begin
                n_cnt = cnt_next;
                n_tag = tag_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tag <= 1'b0;
            r_buf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_tag <= n_tag;
            r_buf <= n_buf;
        end
    end
endmodule

// ===== design/cfe_back.sv =====
module cfe_back import cfe_pkg::*; #(
    parameter int MAX_FRAME   = 64,
    parameter int SLOT_BYTES  = 41,
    parameter int MAX_PAYLOAD = 42
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  logic [$clog2(MAX_FRAME+1)-1:0] i_job_n,
    input  logic                           i_job_tag,
    input  logic                           i_job_buf,
    output logic                           o_job_pop,
    output logic [$clog2(MAX_FRAME):0]     o_frame_raddr,
    input  logic [7:0]                     i_frame_rdata,
    cfe_tx_if.source                       o_tx
);
    localparam int CW  = $clog2(MAX_FRAME + 1);
    localparam int FAW = $clog2(MAX_FRAME);
    localparam int IW  = $clog2(MAX_FRAME + SLOT_BYTES + 32);
    localparam int SD  = 3 * SLOT_BYTES;
    localparam int SAW = $clog2(SD);

    t_bstate       r_state, n_state;
    logic          r_ph, n_ph;
    logic [CW-1:0] r_n, n_n;
    logic          r_buf, n_buf;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_crc, n_crc;
    logic [31:0]   r_rcrc, n_rcrc;
    logic [15:0]   r_dlen, n_dlen;
    logic [15:0]   r_id, n_id;
    logic [1:0]    r_slot, n_slot;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_len, n_len;
    logic [7:0]    r_status, n_status;
    logic [2:0]    r_written, n_written;
    logic          r_diff, n_diff;
    logic [2:0]    r_code, n_code;
    logic          r_ov, n_ov;
    logic [7:0]    r_ob, n_ob;
    logic          r_ol, n_ol;
    logic [2:0]    r_oo, n_oo;

    logic           out_free;
    logic [IW-1:0]  j, f_idx, s_idx, plen;
    logic [SAW-1:0] s_base, s_addr;
    logic [7:0]     s_rdata, genb, newb, oldb;
    logic           s_we;
    logic           id_unsup, id_write;
    logic [1:0]     id_slot;
    logic [2:0]     id_lo;

    assign out_free = !r_ov || o_tx.ready;
    assign j        = (r_state == B_EMIT) ? r_idx - IW'(CRC_BYTES) : r_idx;
    assign plen     = IW'(r_dlen - 16'(HDR_LEN));
    assign id_unsup = (r_id == 16'd0) || (r_id > MSG_ID_MAX);
    assign id_write = !r_id[0] && (plen != '0);
    assign id_lo    = r_id[2:0] - 3'd1;
    assign id_slot  = id_lo[2:1];

    always_comb begin
        case (r_state)
            B_CRC, B_RCRC: f_idx = r_idx + IW'(BODY_OFS);
            B_WR:          f_idx = r_idx + IW'(DATA_OFS);
            default:       f_idx = r_idx;
        endcase
        case (r_state)
            B_RCRC:  s_idx = r_idx - IW'(STATUS_IDX + 1);
            B_EMIT:  s_idx = r_idx - IW'(STATUS_IDX + 1 + CRC_BYTES);
            default: s_idx = r_idx;
        endcase
        case (r_slot)
            2'd0:    s_base = '0;
            2'd1:    s_base = SAW'(SLOT_BYTES);
            default: s_base = SAW'(2 * SLOT_BYTES);
        endcase
    end

    assign o_frame_raddr = {r_buf, f_idx[FAW-1:0]};
    assign s_addr        = s_base + SAW'(s_idx);
    assign newb          = (r_idx < plen) ? i_frame_rdata : 8'd0;
    assign oldb          = r_written[r_slot] ? s_rdata : 8'd0;
    assign s_we          = (r_state == B_WR) && r_ph;

    always_comb begin
        if (j == IW'(0)) begin
            genb = r_len[7:0];
        end else if (j == IW'(1)) begin
            genb = 8'd0;
        end else if (j < IW'(6)) begin
            genb = i_frame_rdata;
        end else if (j < IW'(10)) begin
            genb = 8'd0;
        end else if (j < IW'(STATUS_IDX)) begin
            genb = i_frame_rdata;
        end else if (j == IW'(STATUS_IDX)) begin
            genb = r_status;
        end else begin
            genb = s_rdata;
        end
    end

    cfe_ram #(.W(8), .DEPTH(SD)) u_slots (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_addr),
        .i_wdata (newb),
        .i_raddr (s_addr),
        .o_rdata (s_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    if (!i_job_tag || i_job_n < CW'(MIN_FRAME)) begin
                        n_state = B_DROP;
                    end else begin
                        n_state = B_HDR;
                    end
                end
            end
            B_HDR: begin
                if (r_ph && r_idx == IW'(LEN_HI_OFS)) n_state = B_LCHK;
            end
            B_LCHK: begin
                if ((17'(r_dlen) + 17'(BODY_OFS)) > 17'(r_n)) n_state = B_DROP;
                else n_state = B_CRC;
            end
            B_CRC: begin
                if (!r_ph && 16'(r_idx) == r_dlen) n_state = B_CCHK;
            end
            B_CCHK: begin
                if (~r_crc != r_rcrc || r_dlen < 16'(HDR_LEN)
                        || r_dlen > 16'(HDR_LEN + MAX_PAYLOAD)) begin
                    n_state = B_DROP;
                end else begin
                    n_state = B_IDR;
                end
            end
            B_IDR: begin
                if (r_ph && r_idx == IW'(ID_HI_OFS)) n_state = B_DISP;
            end
            B_DISP: begin
                if (id_unsup) n_state = B_RSTART;
                else if (id_write) n_state = B_WR;
                else if (r_written[id_slot]) n_state = B_SCAN;
                else n_state = B_RSTART;
            end
            B_WR: begin
                if (!r_ph && r_idx == IW'(SLOT_BYTES)) n_state = B_RSTART;
            end
            B_SCAN: begin
                if ((!r_ph && r_idx == IW'(SLOT_BYTES)) || (r_ph && s_rdata == 8'd0)) begin
                    n_state = B_RSTART;
                end
            end
            B_RSTART: n_state = B_RCRC;
            B_RCRC: begin
                if (!r_ph && r_idx == r_len) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (r_ph && out_free && r_idx == r_len + IW'(CRC_BYTES - 1)) n_state = B_DONE;
            end
            B_DROP: begin
                if (out_free) n_state = B_DONE;
            end
            B_DONE:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_ph      = r_ph;
        n_n       = r_n;
        n_buf     = r_buf;
        n_idx     = r_idx;
        n_crc     = r_crc;
        n_rcrc    = r_rcrc;
        n_dlen    = r_dlen;
        n_id      = r_id;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_status  = r_status;
        n_written = r_written;
        n_diff    = r_diff;
        n_code    = r_code;
        n_ov      = r_ov && !o_tx.ready;
        n_ob      = r_ob;
        n_ol      = r_ol;
        n_oo      = r_oo;
        o_job_pop = 1'b0;
        case (r_state)
            B_IDLE: begin
                n_n    = i_job_n;
                n_buf  = i_job_buf;
                n_idx  = '0;
                n_ph   = 1'b0;
                n_code = i_job_tag ? OC_SHORT : OC_BAD_ID;
            end
            B_HDR: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    if (r_idx < IW'(BODY_OFS)) n_rcrc[r_idx[1:0]*8 +: 8] = i_frame_rdata;
                    else n_dlen[r_idx[0]*8 +: 8] = i_frame_rdata;
                    n_idx = r_idx + IW'(1);
                end
            end
            B_LCHK: begin
                n_code = OC_LEN;
                n_idx  = '0;
                n_crc  = CRC_INIT;
            end
            B_CRC: begin
                if (r_ph) begin
                    n_crc = crc_byte(r_crc, i_frame_rdata);
                    n_idx = r_idx + IW'(1);
                    n_ph  = 1'b0;
                end else if (16'(r_idx) != r_dlen) begin
                    n_ph = 1'b1;
                end
            end
            B_CCHK: begin
                n_code = (~r_crc != r_rcrc) ? OC_CRC : OC_LEN;
                n_idx  = IW'(ID_LO_OFS);
            end
            B_IDR: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    n_id[r_idx[0]*8 +: 8] = i_frame_rdata;
                    n_idx = r_idx + IW'(1);
                end
            end
            B_DISP: begin
                n_slot   = id_slot;
                n_status = ST_OK;
                n_cnt    = IW'(1);
                n_idx    = '0;
                n_diff   = 1'b0;
                if (id_unsup) n_status = ST_UNSUP;
                else if (!id_write && !r_written[id_slot]) n_status = ST_EMPTY;
            end
            B_WR: begin
                if (r_ph) begin
                    n_diff = r_diff || (newb != oldb);
                    n_idx  = r_idx + IW'(1);
                    n_ph   = 1'b0;
                end else if (r_idx == IW'(SLOT_BYTES)) begin
                    if (r_diff) n_written[r_slot] = 1'b1;
                end else begin
                    n_ph = 1'b1;
                end
            end
            B_SCAN: begin
                if (r_ph) begin
                    n_ph = 1'b0;
                    if (s_rdata == 8'd0) n_cnt = r_idx + IW'(1);
                    else n_idx = r_idx + IW'(1);
                end else if (r_idx == IW'(SLOT_BYTES)) begin
                    n_cnt = r_idx + IW'(1);
                end else begin
                    n_ph = 1'b1;
                end
            end
            B_RSTART: begin
                n_len = r_cnt + IW'(HDR_LEN);
                n_crc = CRC_INIT;
                n_idx = '0;
                n_ph  = 1'b0;
            end
            B_RCRC: begin
                if (r_ph) begin
                    n_crc = crc_byte(r_crc, genb);
                    n_idx = r_idx + IW'(1);
                    n_ph  = 1'b0;
                end else if (r_idx == r_len) begin
                    n_crc = ~r_crc;
                    n_idx = '0;
                end else begin
                    n_ph = 1'b1;
                end
            end
            B_EMIT: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (out_free) begin
                    n_ov  = 1'b1;
                    n_ob  = (r_idx < IW'(CRC_BYTES)) ? r_crc[r_idx[1:0]*8 +: 8] : genb;
                    n_ol  = (r_idx == r_len + IW'(CRC_BYTES - 1));
                    n_oo  = OC_BYTE;
                    n_idx = r_idx + IW'(1);
                    n_ph  = 1'b0;
                end
            end
            B_DROP: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ob = 8'd0;
                    n_ol = 1'b1;
                    n_oo = r_code;
                end
            end
            B_DONE: begin
                o_job_pop = 1'b1;
            end
            default: begin
                n_ph = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_ph      <= 1'b0;
            r_written <= 3'd0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ph      <= n_ph;
            r_written <= n_written;
            r_ov      <= n_ov;
        end
        r_n      <= n_n;
        r_buf    <= n_buf;
        r_idx    <= n_idx;
        r_crc    <= n_crc;
        r_rcrc   <= n_rcrc;
        r_dlen   <= n_dlen;
        r_id     <= n_id;
        r_slot   <= n_slot;
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_status <= n_status;
        r_diff   <= n_diff;
        r_code   <= n_code;
        r_ob     <= n_ob;
        r_ol     <= n_ol;
        r_oo     <= n_oo;
    end

    assign o_tx.valid   = r_ov;
    assign o_tx.tx_byte = r_ob;
    assign o_tx.tx_last = r_ol;
    assign o_tx.outcome = r_oo;
endmodule

// ===== design/crc32_command_frame_engine.sv =====
// Command engine for CRC-32 checked reports. Report bytes come in on i_rx,
// one per transfer, with report_tag sampled on the first byte and
// end_of_report set on the last. Each closed report yields on o_tx either
// one drop item (tx_byte zero, tx_last set, outcome giving the reason) or
// the response bytes from the CRC field onward, with tx_last on the final
// byte and outcome zero.
// The intake stores bytes into one of two frame buffers at one byte per
// cycle and queues each closed report for the command sequencer. Intake
// stalls only while both buffers hold reports that are not yet answered.
// The sequencer reads each byte in an address phase and a data phase on
// every pass over a memory: the header, the CRC check, a slot write or
// scan, and the response's CRC pass and output pass.
// A receiver stall holds the single output register and the sequencer
// waits; intake continues into the free buffer.
// Reset clears the slot written flags, so every slot reads as unwritten.
module crc32_command_frame_engine import cfe_pkg::*; #(
    parameter int MAX_FRAME   = 64,
    parameter int SLOT_BYTES  = 41,
    parameter int MAX_PAYLOAD = 42
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cfe_rx_if.sink   i_rx,
    cfe_tx_if.source o_tx
);
    localparam int CW  = $clog2(MAX_FRAME + 1);
    localparam int FAW = $clog2(MAX_FRAME);
    localparam int QW  = CW + 2;

    logic          q_push, q_full, q_valid, q_pop;
    logic [CW-1:0] f_job_n;
    logic          f_job_tag, f_job_buf;
    logic [QW-1:0] q_data;
    logic          f_we;
    logic [FAW:0]  f_waddr, b_raddr;
    logic [7:0]    f_wdata, b_rdata;

    cfe_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_job_n   (f_job_n),
        .o_job_tag (f_job_tag),
        .o_job_buf (f_job_buf),
        .o_we      (f_we),
        .o_waddr   (f_waddr),
        .o_wdata   (f_wdata)
    );

    cfe_ram #(.W(8), .DEPTH(2 * (1 << FAW))) u_frames (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    cfe_jobq #(.W(QW)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_job_n, f_job_tag, f_job_buf}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    cfe_back #(
        .MAX_FRAME   (MAX_FRAME),
        .SLOT_BYTES  (SLOT_BYTES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job_n       (q_data[QW-1:2]),
        .i_job_tag     (q_data[1]),
        .i_job_buf     (q_data[0]),
        .o_job_pop     (q_pop),
        .o_frame_raddr (b_raddr),
        .i_frame_rdata (b_rdata),
        .o_tx          (o_tx)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("Report queued while both frame buffers are busy.");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("Report released from an empty queue.");

    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx.valid && o_tx.outcome != OC_BYTE) |-> (o_tx.tx_last && o_tx.tx_byte == 8'd0))
        else $error("Drop item is not a single zero transfer.");
endmodule
